// ----- design/ddagrc_pkg.sv -----
package ddagrc_pkg;

  localparam int FRAC_BITS = 16;
  localparam int POS_W     = 22;
  localparam int VEC_W     = 18;
  localparam int SW_W      = 13;
  localparam int COL_W     = 12;
  localparam int CELL_W    = 6;
  localparam int DIST_W    = 32;
  localparam int CAM_W     = 18;
  localparam int RAY_W     = 19;
  localparam int SQ_W      = 38;
  localparam int ROOT_W    = 19;
  localparam int ROOT_IT_W = 5;
  localparam int DIV_NW    = 35;
  localparam int DIV_DW    = 19;
  localparam int DIV_CW    = 6;
  localparam int QDEPTH    = 4;
  localparam int CFG_W     = 22;
  localparam int CFG_IW    = 3;

  localparam logic [DIST_W-1:0] ONE_FX = 32'h0001_0000;
  localparam logic [DIST_W-1:0] SAT32  = 32'hFFFF_FFFF;

  localparam logic [CFG_IW-1:0] REG_POS_X        = 3'd0;
  localparam logic [CFG_IW-1:0] REG_POS_Y        = 3'd1;
  localparam logic [CFG_IW-1:0] REG_DIR_X        = 3'd2;
  localparam logic [CFG_IW-1:0] REG_DIR_Y        = 3'd3;
  localparam logic [CFG_IW-1:0] REG_PLANE_X      = 3'd4;
  localparam logic [CFG_IW-1:0] REG_PLANE_Y      = 3'd5;
  localparam logic [CFG_IW-1:0] REG_SCREEN_WIDTH = 3'd6;

  localparam logic [0:0] OP_WRITE = 1'b0;
  localparam logic [0:0] OP_CAST  = 1'b1;

  typedef struct packed {
    logic [POS_W-1:0]        pos_x;
    logic [POS_W-1:0]        pos_y;
    logic signed [VEC_W-1:0] dir_x;
    logic signed [VEC_W-1:0] dir_y;
    logic signed [VEC_W-1:0] plane_x;
    logic signed [VEC_W-1:0] plane_y;
    logic [SW_W-1:0]         screen_width;
  } cfg_t;

  typedef struct packed {
    logic [0:0]        op;
    logic [COL_W-1:0]  column;
    logic [CELL_W-1:0] cell_x;
    logic [CELL_W-1:0] cell_y;
    logic              is_wall;
    logic              wr_ok;
  } qword_t;

  typedef struct packed {
    logic [CELL_W-1:0] hit_x;
    logic [CELL_W-1:0] hit_y;
    logic              hit_side;
    logic [DIST_W-1:0] side_dist_x;
    logic [DIST_W-1:0] side_dist_y;
    logic [DIST_W-1:0] delta_dist_x;
    logic [DIST_W-1:0] delta_dist_y;
    logic              escaped;
  } res_t;

  typedef enum logic [4:0] {
    B_CLEAR,
    B_IDLE,
    B_CAM_WAIT,
    B_RAY_X,
    B_RAY_Y,
    B_SQ_X,
    B_SQ_Y,
    B_SQRT,
    B_DDX,
    B_DDX_WAIT,
    B_DDY,
    B_DDY_WAIT,
    B_SIDE_X,
    B_SIDE_Y,
    B_START,
    B_STEP,
    B_CHECK,
    B_DONE
  } back_state_t;

  // A zero screen width counts as one column.
  function automatic logic [SW_W-1:0] eff_width(input logic [SW_W-1:0] sw);
    return (sw == '0) ? SW_W'(1) : sw;
  endfunction

endpackage

// ----- design/dda_grid_ray_caster.sv -----
// Grid ray caster over a square wall bitmap.
// Input channel (in_valid/in_stall): op selects a map write (cell_x, cell_y,
// is_wall) or a ray cast for one screen column. Each word is taken at an
// edge with in_valid high and in_stall low, and moves through a four-word
// queue to the execution sequencer. Map writes give no result; casts give
// one result word on the output channel (out_valid/out_stall), held steady
// while out_stall is high.
// The camera divide and both delta divides run on one shared divider at one
// bit per cycle, the square root is found iteratively, and each walk step
// moves to the next cell and then checks it with a registered map read.
// A map write is done by the sequencer straight from its idle state.
// After reset the wall map is cleared one cell per cycle with in_stall held
// high; configuration writes are taken meanwhile.
// Configuration (cfg_we, cfg_index, cfg_data) must only change while idle.
// While the receiver stalls, one result and one cast in progress are held and
// words are still taken until the queue and the input hold register fill.
module dda_grid_ray_caster import ddagrc_pkg::*; #(
  parameter int MAP_DIM = 64
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_we,
  input  logic [CFG_IW-1:0] cfg_index,
  input  logic [CFG_W-1:0]  cfg_data,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [0:0]        op,
  input  logic [COL_W-1:0]  column,
  input  logic [CELL_W-1:0] cell_x,
  input  logic [CELL_W-1:0] cell_y,
  input  logic              is_wall,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [CELL_W-1:0] hit_x,
  output logic [CELL_W-1:0] hit_y,
  output logic              hit_side,
  output logic [DIST_W-1:0] side_dist_x,
  output logic [DIST_W-1:0] side_dist_y,
  output logic [DIST_W-1:0] delta_dist_x,
  output logic [DIST_W-1:0] delta_dist_y,
  output logic              escaped
);

  cfg_t   cfg;
  logic   clearing;
  logic   q_push, q_pop, q_full, q_empty;
  qword_t q_wdata, q_rdata;
  res_t   res;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.pos_x        <= 22'd163840;
      cfg.pos_y        <= 22'd163840;
      cfg.dir_x        <= -18'sd65536;
      cfg.dir_y        <= 18'sd0;
      cfg.plane_x      <= 18'sd0;
      cfg.plane_y      <= 18'sd43254;
      cfg.screen_width <= 13'd640;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_POS_X:        cfg.pos_x        <= cfg_data;
        REG_POS_Y:        cfg.pos_y        <= cfg_data;
        REG_DIR_X:        cfg.dir_x        <= $signed(cfg_data[VEC_W-1:0]);
        REG_DIR_Y:        cfg.dir_y        <= $signed(cfg_data[VEC_W-1:0]);
        REG_PLANE_X:      cfg.plane_x      <= $signed(cfg_data[VEC_W-1:0]);
        REG_PLANE_Y:      cfg.plane_y      <= $signed(cfg_data[VEC_W-1:0]);
        REG_SCREEN_WIDTH: cfg.screen_width <= cfg_data[SW_W-1:0];
        default: begin
        end
      endcase
    end
  end

  ddagrc_front #(.MAP_DIM(MAP_DIM)) u_front (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .clearing (clearing),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .op       (op),
    .column   (column),
    .cell_x   (cell_x),
    .cell_y   (cell_y),
    .is_wall  (is_wall),
    .q_push   (q_push),
    .q_wdata  (q_wdata),
    .q_full   (q_full)
  );

  ddagrc_fifo u_fifo (
    .clk   (clk),
    .rst   (rst),
    .push  (q_push),
    .wdata (q_wdata),
    .pop   (q_pop),
    .rdata (q_rdata),
    .full  (q_full),
    .empty (q_empty)
  );

  ddagrc_back #(.MAP_DIM(MAP_DIM)) u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .clearing  (clearing),
    .q_rdata   (q_rdata),
    .q_empty   (q_empty),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .res       (res)
  );

  assign hit_x        = res.hit_x;
  assign hit_y        = res.hit_y;
  assign hit_side     = res.hit_side;
  assign side_dist_x  = res.side_dist_x;
  assign side_dist_y  = res.side_dist_y;
  assign delta_dist_x = res.delta_dist_x;
  assign delta_dist_y = res.delta_dist_y;
  assign escaped      = res.escaped;

endmodule

// ----- design/ddagrc_front.sv -----
module ddagrc_front import ddagrc_pkg::*; #(
  parameter int MAP_DIM = 64
) (
  input  logic              clk,
  input  logic              rst,
  input  cfg_t              cfg,
  input  logic              clearing,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [0:0]        op,
  input  logic [COL_W-1:0]  column,
  input  logic [CELL_W-1:0] cell_x,
  input  logic [CELL_W-1:0] cell_y,
  input  logic              is_wall,
  output logic              q_push,
  output qword_t            q_wdata,
  input  logic              q_full
);

  logic            hold_valid;
  qword_t          hold;
  qword_t          word_in;
  logic [SW_W-1:0] w;
  logic            accept;

  assign w = eff_width(cfg.screen_width);

  // Columns at or past the width clamp to the last column.
  always_comb begin
    word_in.op      = op;
    word_in.column  = ({1'b0, column} >= w) ? COL_W'(w - SW_W'(1)) : column;
    word_in.cell_x  = cell_x;
    word_in.cell_y  = cell_y;
    word_in.is_wall = is_wall;
    word_in.wr_ok   = (int'(cell_x) < MAP_DIM) && (int'(cell_y) < MAP_DIM);
  end

  assign q_push   = hold_valid && !q_full;
  assign in_stall = clearing || (hold_valid && q_full);
  assign accept   = in_valid && !in_stall;
  assign q_wdata  = hold;

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (accept) begin
      hold_valid <= 1'b1;
    end else if (q_push) begin
      hold_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      hold <= word_in;
    end
  end

endmodule

// ----- design/ddagrc_fifo.sv -----
module ddagrc_fifo import ddagrc_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  input  logic   push,
  input  qword_t wdata,
  input  logic   pop,
  output qword_t rdata,
  output logic   full,
  output logic   empty
);

  localparam int PW = $clog2(QDEPTH);

  qword_t        slots [QDEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [PW:0]   count;

  assign full  = (count == (PW+1)'(QDEPTH));
  assign empty = (count == '0);
  assign rdata = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(QDEPTH - 1)) ? '0 : wr_ptr + PW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(QDEPTH - 1)) ? '0 : rd_ptr + PW'(1);
      end
      case ({push, pop})
        2'b10:   count <= count + (PW+1)'(1);
        2'b01:   count <= count - (PW+1)'(1);
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= wdata;
    end
  end

`ifndef SYNTHESIS
  a_no_pop_empty: assert property (@(posedge clk) disable iff (rst) pop |-> !empty)
    else $error("queue popped while empty");
  a_no_push_full: assert property (@(posedge clk) disable iff (rst) push |-> !full)
    else $error("queue pushed while full");
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= (PW+1)'(QDEPTH))
    else $error("queue count out of range");
`endif

endmodule

// ----- design/ddagrc_div.sv -----
module ddagrc_div import ddagrc_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [DIV_NW-1:0] num,
  input  logic [DIV_DW-1:0] den,
  output logic              done,
  output logic [DIV_NW-1:0] quo
);

  // Restoring division, one quotient bit per cycle. The numerator shifts out
  // of quo at the top while quotient bits shift in at the bottom.
  logic              busy;
  logic [DIV_CW-1:0] cnt;
  logic [DIV_DW-1:0] den_r;
  logic [DIV_DW-1:0] rem;
  logic [DIV_DW:0]   rem_sh;
  logic              ge;

  assign rem_sh = {rem, quo[DIV_NW-1]};
  assign ge     = rem_sh >= {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
      end else if (busy && cnt == DIV_CW'(DIV_NW - 1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      cnt   <= '0;
      rem   <= '0;
      den_r <= den;
      quo   <= num;
    end else if (busy) begin
      cnt <= cnt + DIV_CW'(1);
      rem <= ge ? DIV_DW'(rem_sh - {1'b0, den_r}) : rem_sh[DIV_DW-1:0];
      quo <= {quo[DIV_NW-2:0], ge};
    end
  end

endmodule

// ----- design/ddagrc_back.sv -----
module ddagrc_back import ddagrc_pkg::*; #(
  parameter int MAP_DIM = 64
) (
  input  logic   clk,
  input  logic   rst,
  input  cfg_t   cfg,
  output logic   clearing,
  input  qword_t q_rdata,
  input  logic   q_empty,
  output logic   q_pop,
  output logic   out_valid,
  input  logic   out_stall,
  output res_t   res
);

  localparam int NCELL = MAP_DIM * MAP_DIM;
  localparam int AW    = $clog2(NCELL);
  localparam int XW    = ($clog2(MAP_DIM) > CELL_W) ? $clog2(MAP_DIM) : CELL_W;
  localparam int CW    = XW + 2;

  back_state_t state, state_next;

  logic wall_mem [NCELL];
  logic mem_rdata;

  logic              div_start, div_done;
  logic [DIV_NW-1:0] div_num, div_quo;
  logic [DIV_DW-1:0] div_den;

  logic              mem_we, mem_wdata, mem_re;
  logic [AW-1:0]     mem_waddr, mem_raddr;
  logic [AW-1:0]     clr_cnt;

  logic signed [RAY_W-1:0]   mul_a, mul_b;
  logic signed [2*RAY_W-1:0] mul_p;
  logic [16:0]               smul_a;
  logic [DIST_W-1:0]         smul_b;
  logic [48:0]               smul_p;
  logic [32:0]               side_val;

  logic signed [CAM_W-1:0] cam;
  logic signed [RAY_W-1:0] rx, ry;
  logic [RAY_W-1:0]        abs_rx, abs_ry;
  logic [SQ_W-1:0]         sq;
  logic [ROOT_W-1:0]       root;
  logic [ROOT_W+1:0]       rt_rem;
  logic [ROOT_IT_W-1:0]    rt_cnt;
  logic [ROOT_W+3:0]       rt_sh, rt_trial;
  logic                    rt_ge;
  logic [DIST_W-1:0]       ddx, ddy, sdx, sdy, quo_sat;
  logic [16:0]             dist_x, dist_y;
  logic [CW-1:0]           mx, my, nx, ny, sx0, sy0;
  logic                    side, esc, take_x, next_in, start_in;
  logic [32:0]             sum_x, sum_y;
  logic                    out_load, out_free;

  ddagrc_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quo   (div_quo)
  );

  assign clearing = (state == B_CLEAR);
  assign out_free = !out_valid || !out_stall;

  assign abs_rx  = rx[RAY_W-1] ? RAY_W'(-rx) : RAY_W'(rx);
  assign abs_ry  = ry[RAY_W-1] ? RAY_W'(-ry) : RAY_W'(ry);
  assign quo_sat = (div_quo[DIV_NW-1:DIST_W] != '0) ? SAT32 : div_quo[DIST_W-1:0];

  assign mul_p    = mul_a * mul_b;
  assign smul_p   = smul_a * smul_b;
  assign side_val = smul_p[48:FRAC_BITS];

  // Distance from the viewer to the first grid line, in the direction of travel.
  assign dist_x = rx[RAY_W-1] ? {1'b0, cfg.pos_x[FRAC_BITS-1:0]}
                              : 17'h10000 - {1'b0, cfg.pos_x[FRAC_BITS-1:0]};
  assign dist_y = ry[RAY_W-1] ? {1'b0, cfg.pos_y[FRAC_BITS-1:0]}
                              : 17'h10000 - {1'b0, cfg.pos_y[FRAC_BITS-1:0]};

  assign rt_sh    = {rt_rem, sq[SQ_W-1:SQ_W-2]};
  assign rt_trial = {2'b00, root, 2'b01};
  assign rt_ge    = rt_sh >= rt_trial;

  assign sx0      = CW'(cfg.pos_x[POS_W-1:FRAC_BITS]);
  assign sy0      = CW'(cfg.pos_y[POS_W-1:FRAC_BITS]);
  assign start_in = (sx0 < CW'(MAP_DIM)) && (sy0 < CW'(MAP_DIM));

  assign take_x = sdx < sdy;
  assign sum_x  = {1'b0, sdx} + {1'b0, ddx};
  assign sum_y  = {1'b0, sdy} + {1'b0, ddy};
  always_comb begin
    nx = mx;
    ny = my;
    if (take_x) begin
      nx = rx[RAY_W-1] ? mx - CW'(1) : mx + CW'(1);
    end else begin
      ny = ry[RAY_W-1] ? my - CW'(1) : my + CW'(1);
    end
  end
  // A coordinate of minus one has its top bit set and fails the compare too.
  assign next_in = (nx < CW'(MAP_DIM)) && (ny < CW'(MAP_DIM));

  always_comb begin
    state_next = state;
    case (state)
      B_CLEAR:    if (clr_cnt == AW'(NCELL - 1)) state_next = B_IDLE;
      B_IDLE:     if (!q_empty && q_rdata.op == OP_CAST) state_next = B_CAM_WAIT;
      B_CAM_WAIT: if (div_done) state_next = B_RAY_X;
      B_RAY_X:    state_next = B_RAY_Y;
      B_RAY_Y:    state_next = B_SQ_X;
      B_SQ_X:     state_next = B_SQ_Y;
      B_SQ_Y:     state_next = B_SQRT;
      B_SQRT:     if (rt_cnt == ROOT_IT_W'(ROOT_W - 1)) state_next = B_DDX;
      B_DDX:      state_next = (ry == '0 || rx == '0) ? B_DDY : B_DDX_WAIT;
      B_DDX_WAIT: if (div_done) state_next = B_DDY;
      B_DDY:      state_next = (rx == '0 || ry == '0) ? B_SIDE_X : B_DDY_WAIT;
      B_DDY_WAIT: if (div_done) state_next = B_SIDE_X;
      B_SIDE_X:   state_next = B_SIDE_Y;
      B_SIDE_Y:   state_next = B_START;
      B_START:    state_next = start_in ? B_STEP : B_DONE;
      B_STEP:     state_next = next_in ? B_CHECK : B_DONE;
      B_CHECK:    state_next = mem_rdata ? B_DONE : B_STEP;
      B_DONE:     if (out_free) state_next = B_IDLE;
      default:    state_next = B_IDLE;
    endcase
  end

  always_comb begin
    q_pop     = 1'b0;
    div_start = 1'b0;
    div_num   = {6'b0, q_rdata.column, 17'b0};
    div_den   = {6'b0, eff_width(cfg.screen_width)};
    mem_we    = 1'b0;
    mem_waddr = clr_cnt;
    mem_wdata = 1'b0;
    mem_re    = 1'b0;
    mem_raddr = AW'(AW'(nx[XW-1:0]) * AW'(MAP_DIM)) + AW'(ny[XW-1:0]);
    mul_a     = $signed({cfg.plane_x[VEC_W-1], cfg.plane_x});
    mul_b     = $signed({cam[CAM_W-1], cam});
    smul_a    = dist_x;
    smul_b    = ddx;
    out_load  = 1'b0;
    case (state)
      B_CLEAR: begin
        mem_we = 1'b1;
      end
      B_IDLE: begin
        if (!q_empty) begin
          q_pop = 1'b1;
          if (q_rdata.op == OP_CAST) begin
            div_start = 1'b1;
          end else begin
            mem_we    = q_rdata.wr_ok;
            mem_wdata = q_rdata.is_wall;
            mem_waddr = AW'(AW'(q_rdata.cell_x) * AW'(MAP_DIM)) + AW'(q_rdata.cell_y);
          end
        end
      end
      B_RAY_Y: begin
        mul_a = $signed({cfg.plane_y[VEC_W-1], cfg.plane_y});
      end
      B_SQ_X: begin
        mul_a = rx;
        mul_b = rx;
      end
      B_SQ_Y: begin
        mul_a = ry;
        mul_b = ry;
      end
      B_DDX: begin
        div_start = (ry != '0) && (rx != '0);
        div_num   = {root, 16'b0};
        div_den   = abs_rx;
      end
      B_DDY: begin
        div_start = (rx != '0) && (ry != '0);
        div_num   = {root, 16'b0};
        div_den   = abs_ry;
      end
      B_SIDE_Y: begin
        smul_a = dist_y;
        smul_b = ddy;
      end
      B_STEP: begin
        mem_re = next_in;
      end
      B_DONE: begin
        out_load = out_free;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= B_CLEAR;
      clr_cnt   <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == B_CLEAR) begin
        clr_cnt <= clr_cnt + AW'(1);
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      B_CAM_WAIT: if (div_done) cam <= $signed({1'b0, div_quo[16:0]} - 18'h10000);
      B_RAY_X: rx <= $signed({cfg.dir_x[VEC_W-1], cfg.dir_x}) + $signed(mul_p[34:16]);
      B_RAY_Y: ry <= $signed({cfg.dir_y[VEC_W-1], cfg.dir_y}) + $signed(mul_p[34:16]);
      B_SQ_X:  sq <= $unsigned(mul_p);
      B_SQ_Y: begin
        sq     <= sq + $unsigned(mul_p);
        root   <= '0;
        rt_rem <= '0;
        rt_cnt <= '0;
      end
      B_SQRT: begin
        sq     <= {sq[SQ_W-3:0], 2'b00};
        rt_cnt <= rt_cnt + ROOT_IT_W'(1);
        root   <= {root[ROOT_W-2:0], rt_ge};
        rt_rem <= rt_ge ? (ROOT_W+2)'(rt_sh - rt_trial) : rt_sh[ROOT_W+1:0];
      end
      B_DDX: begin
        if (ry == '0) ddx <= '0;
        else if (rx == '0) ddx <= ONE_FX;
      end
      B_DDX_WAIT: if (div_done) ddx <= quo_sat;
      B_DDY: begin
        if (rx == '0) ddy <= '0;
        else if (ry == '0) ddy <= ONE_FX;
      end
      B_DDY_WAIT: if (div_done) ddy <= quo_sat;
      B_SIDE_X: sdx <= side_val[32] ? SAT32 : side_val[31:0];
      B_SIDE_Y: sdy <= side_val[32] ? SAT32 : side_val[31:0];
      B_START: begin
        mx   <= sx0;
        my   <= sy0;
        side <= 1'b0;
        esc  <= !start_in;
      end
      B_STEP: begin
        if (take_x) begin
          sdx  <= sum_x[32] ? SAT32 : sum_x[31:0];
          side <= 1'b0;
        end else begin
          sdy  <= sum_y[32] ? SAT32 : sum_y[31:0];
          side <= 1'b1;
        end
        if (next_in) begin
          mx <= nx;
          my <= ny;
        end else begin
          esc <= 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      res.hit_x        <= mx[CELL_W-1:0];
      res.hit_y        <= my[CELL_W-1:0];
      res.hit_side     <= side;
      res.side_dist_x  <= sdx;
      res.side_dist_y  <= sdy;
      res.delta_dist_x <= ddx;
      res.delta_dist_y <= ddy;
      res.escaped      <= esc;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      wall_mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      mem_rdata <= wall_mem[mem_raddr];
    end
  end

`ifndef SYNTHESIS
  a_clear_quiet: assert property (@(posedge clk) disable iff (rst)
    (state == B_CLEAR) |-> !out_valid)
    else $error("result shown during the clearing pass");
  a_div_done_waiting: assert property (@(posedge clk) disable iff (rst)
    div_done |-> (state == B_CAM_WAIT || state == B_DDX_WAIT || state == B_DDY_WAIT))
    else $error("divider finished outside a wait state");
  a_walk_in_map: assert property (@(posedge clk) disable iff (rst)
    (state == B_STEP) |-> (mx < CW'(MAP_DIM) && my < CW'(MAP_DIM)))
    else $error("walk cell outside the map");
`endif

endmodule

// ----- tb/sv/tb_dda_grid_ray_caster.sv -----
module tb_dda_grid_ray_caster import ddagrc_pkg::*;;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int DIM = 64;
  localparam longint CYCLE_LIMIT = 4000000;

  typedef struct {
    logic [0:0]        op;
    logic [COL_W-1:0]  column;
    logic [CELL_W-1:0] cx;
    logic [CELL_W-1:0] cy;
    logic              wall;
    bit                known;
    res_t              hit;
  } row_t;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              cfg_we = 1'b0;
  logic [CFG_IW-1:0] cfg_index = '0;
  logic [CFG_W-1:0]  cfg_data = '0;
  logic              in_valid = 1'b0;
  logic              in_stall;
  logic [0:0]        op = OP_WRITE;
  logic [COL_W-1:0]  column = '0;
  logic [CELL_W-1:0] cell_x = '0;
  logic [CELL_W-1:0] cell_y = '0;
  logic              is_wall = 1'b0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic [CELL_W-1:0] hit_x;
  logic [CELL_W-1:0] hit_y;
  logic              hit_side;
  logic [DIST_W-1:0] side_dist_x;
  logic [DIST_W-1:0] side_dist_y;
  logic [DIST_W-1:0] delta_dist_x;
  logic [DIST_W-1:0] delta_dist_y;
  logic              escaped;

  // Shadow copy of the view registers and the wall bitmap.
  logic [POS_W-1:0]        view_pos_x, view_pos_y;
  logic signed [VEC_W-1:0] view_dir_x, view_dir_y, view_plane_x, view_plane_y;
  logic [SW_W-1:0]         view_width;
  bit                      wall_cells [DIM][DIM];

  res_t   pending_hits[$];
  int     errors = 0;
  int     idle_pct = 0;
  int     stall_pct = 0;
  int     hold_left = 0;
  longint cycles = 0;

  dda_grid_ray_caster i_dut (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left--;
    end else begin
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  always @(posedge clk) begin
    res_t want;
    if (!rst && out_valid && !out_stall) begin
      if (pending_hits.size() == 0) begin
        $error("result word with no cast outstanding");
        errors++;
      end else begin
        want = pending_hits.pop_front();
        if (hit_x !== want.hit_x) begin
          $error("hit_x: expected %0d, got %0d", want.hit_x, hit_x);
          errors++;
        end
        if (hit_y !== want.hit_y) begin
          $error("hit_y: expected %0d, got %0d", want.hit_y, hit_y);
          errors++;
        end
        if (hit_side !== want.hit_side) begin
          $error("hit_side: expected %0d, got %0d", want.hit_side, hit_side);
          errors++;
        end
        if (side_dist_x !== want.side_dist_x) begin
          $error("side_dist_x: expected %h, got %h", want.side_dist_x, side_dist_x);
          errors++;
        end
        if (side_dist_y !== want.side_dist_y) begin
          $error("side_dist_y: expected %h, got %h", want.side_dist_y, side_dist_y);
          errors++;
        end
        if (delta_dist_x !== want.delta_dist_x) begin
          $error("delta_dist_x: expected %h, got %h", want.delta_dist_x, delta_dist_x);
          errors++;
        end
        if (delta_dist_y !== want.delta_dist_y) begin
          $error("delta_dist_y: expected %h, got %h", want.delta_dist_y, delta_dist_y);
          errors++;
        end
        if (escaped !== want.escaped) begin
          $error("escaped: expected %0d, got %0d", want.escaped, escaped);
          errors++;
        end
      end
    end
  end

  function automatic longint unsigned clamp32(longint unsigned v);
    return (v > 64'hFFFF_FFFF) ? 64'hFFFF_FFFF : v;
  endfunction

  function automatic longint unsigned root_floor(longint unsigned v);
    longint unsigned r = 0;
    longint unsigned b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  // Distance between grid lines along the axis of a; b is the other component.
  function automatic longint unsigned grid_delta(longint a, longint b);
    longint unsigned ua, ub;
    if (b == 0) return 0;
    if (a == 0) return 64'h1_0000;
    ua = (a < 0) ? -a : a;
    ub = (b < 0) ? -b : b;
    return clamp32((root_floor(ua * ua + ub * ub) << FRAC_BITS) / ua);
  endfunction

  function automatic longint unsigned first_side(logic [POS_W-1:0] p, longint ray,
                                                 longint unsigned dd);
    longint unsigned fr = p[FRAC_BITS-1:0];
    longint unsigned gap = (ray < 0) ? fr : 64'h1_0000 - fr;
    return clamp32((gap * dd) >> FRAC_BITS);
  endfunction

  function automatic res_t trace_ray(logic [COL_W-1:0] col_in);
    res_t r;
    longint unsigned w, c, ddx, ddy, sdx, sdy;
    longint cam, rx, ry, mx, my, nx, ny, sx, sy;
    bit side = 0;
    bit esc = 0;
    w = (view_width == 0) ? 1 : view_width;
    c = (col_in >= w) ? w - 1 : col_in;
    cam = longint'(((2 * c) << FRAC_BITS) / w) - 65536;
    rx = longint'(view_dir_x) + ((longint'(view_plane_x) * cam) >>> FRAC_BITS);
    ry = longint'(view_dir_y) + ((longint'(view_plane_y) * cam) >>> FRAC_BITS);
    ddx = grid_delta(rx, ry);
    ddy = grid_delta(ry, rx);
    sx = (rx < 0) ? -1 : 1;
    sy = (ry < 0) ? -1 : 1;
    sdx = first_side(view_pos_x, rx, ddx);
    sdy = first_side(view_pos_y, ry, ddy);
    mx = view_pos_x >> FRAC_BITS;
    my = view_pos_y >> FRAC_BITS;
    if (mx >= DIM || my >= DIM) begin
      esc = 1;
    end else begin
      forever begin
        nx = mx;
        ny = my;
        if (sdx < sdy) begin
          sdx = clamp32(sdx + ddx);
          nx += sx;
          side = 0;
        end else begin
          sdy = clamp32(sdy + ddy);
          ny += sy;
          side = 1;
        end
        if (nx < 0 || nx >= DIM || ny < 0 || ny >= DIM) begin
          esc = 1;
          break;
        end
        mx = nx;
        my = ny;
        if (wall_cells[mx][my]) break;
      end
    end
    r.hit_x = mx[CELL_W-1:0];
    r.hit_y = my[CELL_W-1:0];
    r.hit_side = side;
    r.side_dist_x = sdx[DIST_W-1:0];
    r.side_dist_y = sdy[DIST_W-1:0];
    r.delta_dist_x = ddx[DIST_W-1:0];
    r.delta_dist_y = ddy[DIST_W-1:0];
    r.escaped = esc;
    return r;
  endfunction

  // Offers one word and returns at the edge where it is taken; valid stays high.
  task automatic offer(row_t row);
    op <= row.op;
    column <= row.column;
    cell_x <= row.cx;
    cell_y <= row.cy;
    is_wall <= row.wall;
    in_valid <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (row.op == OP_CAST) begin
      if (row.known) pending_hits.push_back(row.hit);
      else pending_hits.push_back(trace_ray(row.column));
    end else begin
      wall_cells[row.cx][row.cy] = row.wall;
    end
  endtask

  task automatic sender_gap();
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_hits.size() != 0) @(posedge clk);
    // Map writes left in the queue give no result word.
    repeat (600) @(posedge clk);
  endtask

  task automatic load_view(int unsigned px, int unsigned py,
                           int unsigned dx, int unsigned dy,
                           int unsigned plx, int unsigned ply,
                           int unsigned sw);
    logic [CFG_W-1:0] vals [7];
    logic [CFG_IW-1:0] idx [7];
    vals = '{CFG_W'(POS_W'(px)), CFG_W'(POS_W'(py)), CFG_W'(VEC_W'(dx)),
             CFG_W'(VEC_W'(dy)), CFG_W'(VEC_W'(plx)), CFG_W'(VEC_W'(ply)),
             CFG_W'(SW_W'(sw))};
    idx = '{REG_POS_X, REG_POS_Y, REG_DIR_X, REG_DIR_Y,
            REG_PLANE_X, REG_PLANE_Y, REG_SCREEN_WIDTH};
    for (int i = 0; i < 7; i++) begin
      cfg_we <= 1'b1;
      cfg_index <= idx[i];
      cfg_data <= vals[i];
      @(posedge clk);
    end
    cfg_we <= 1'b0;
    view_pos_x = POS_W'(px);
    view_pos_y = POS_W'(py);
    view_dir_x = VEC_W'(dx);
    view_dir_y = VEC_W'(dy);
    view_plane_x = VEC_W'(plx);
    view_plane_y = VEC_W'(ply);
    view_width = SW_W'(sw);
  endtask

  function automatic row_t map_row(int x, int y, bit w);
    row_t r;
    r = '{default: '0};
    r.op = OP_WRITE;
    r.cx = CELL_W'(x);
    r.cy = CELL_W'(y);
    r.wall = w;
    return r;
  endfunction

  function automatic row_t cast_row(int col);
    row_t r;
    r = '{default: '0};
    r.op = OP_CAST;
    r.column = COL_W'(col);
    return r;
  endfunction

  function automatic row_t known_row(int hx, int hy, bit esc);
    row_t r;
    r = cast_row(100);
    r.known = 1;
    r.hit = '{default: '0};
    r.hit.hit_x = CELL_W'(hx);
    r.hit.hit_y = CELL_W'(hy);
    r.hit.hit_side = 1'b1;
    r.hit.escaped = esc;
    return r;
  endfunction

  function automatic row_t random_row(int wall_pct);
    row_t r;
    r = '{default: '0};
    r.cx = CELL_W'($urandom_range(63));
    r.cy = CELL_W'($urandom_range(63));
    r.wall = ($urandom_range(99) < wall_pct);
    r.column = ($urandom_range(3) == 0) ? COL_W'($urandom_range(4095))
             : COL_W'($urandom_range((view_width == 0) ? 0 : view_width - 1));
    r.op = ($urandom_range(99) < 35) ? OP_WRITE : OP_CAST;
    return r;
  endfunction

  initial begin
    row_t plan[$];
    bit   zeroed;
    int   mode;

    zeroed = 0;
    for (int x = 0; x < DIM; x++)
      for (int y = 0; y < DIM; y++)
        wall_cells[x][y] = 0;
    view_pos_x = POS_W'(163840);
    view_pos_y = POS_W'(163840);
    view_dir_x = VEC_W'(-65536);
    view_dir_y = '0;
    view_plane_x = '0;
    view_plane_y = VEC_W'(43254);
    view_width = SW_W'(640);

    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: map corners, walls around the start cell, column extremes.
    plan = '{map_row(0, 0, 1), map_row(63, 63, 1), map_row(63, 0, 1),
             map_row(0, 63, 1), map_row(1, 2, 1), map_row(5, 5, 1),
             map_row(2, 40, 1), cast_row(0), cast_row(1), cast_row(320),
             cast_row(639), cast_row(640), cast_row(4095), cast_row(2047),
             map_row(1, 2, 0), cast_row(320), map_row(42, 21, 0),
             known_row(2, 40, 0), map_row(2, 40, 0), known_row(2, 63, 1)};
    foreach (plan[i]) begin
      // A ray of zero length steps along y with all distances staying zero.
      if (plan[i].known && !zeroed) begin
        drain();
        load_view(163840, 163840, 0, 0, 0, 0, 640);
        zeroed = 1;
      end
      offer(plan[i]);
    end

    for (int p = 0; p < 12; p++) begin
      drain();
      case (p)
        0: load_view(0, 0, 'h20000, 'h20000, 'h20000, 'h20000, 1);
        1: load_view('h3FFFFF, 'h3FFFFF, 'h1FFFF, 'h1FFFF, 'h1FFFF,
                     'h1FFFF, 4096);
        2: load_view($urandom, $urandom, $urandom, $urandom, $urandom, $urandom, 0);
        3: load_view($urandom, $urandom, 'h10000, 0, 0, 0, 4096);
        default: load_view($urandom, $urandom, $urandom, $urandom, $urandom,
                           $urandom, $urandom_range(1, 4096));
      endcase
      mode = p % 4;
      idle_pct = (mode == 1) ? 83 : (mode == 3) ? 6 : 0;
      stall_pct = (mode == 2) ? 83 : (mode == 3) ? 6 : 0;
      // A long receiver hold lets the block fill up and stall its input.
      if (p == 5) hold_left = 3000;
      for (int n = 0; n < 105; n++) begin
        sender_gap();
        offer(random_row(10 + 5 * p));
        if (p == 6 && n == 50) drain();
      end
    end

    drain();
    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
design/ddagrc_pkg.sv
design/ddagrc_front.sv
design/ddagrc_fifo.sv
design/ddagrc_div.sv
design/ddagrc_back.sv
design/dda_grid_ray_caster.sv
tb/sv/tb_dda_grid_ray_caster.sv
